// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed in %m");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/twl_pkg.sv =====
// ---------------------------------------------------------------------------
// Trie word lookup package
// Widths, operation codes and record types shared by the lookup unit.
// ---------------------------------------------------------------------------
package twl_pkg;

    localparam int NODE_AW    = 16;
    localparam int NODE_COUNT = 1 << NODE_AW;
    localparam int SYM_W      = 8;
    localparam int INFO_BITS  = 20;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    // Operation codes assigned by the front.
    localparam logic [1:0] OP_NODE_WR  = 2'd0;
    localparam logic [1:0] OP_CHAR     = 2'd1;
    localparam logic [1:0] OP_WORD_END = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0]     sym;
        logic [NODE_AW-1:0]   child;
        logic [NODE_AW-1:0]   sib;
        logic [INFO_BITS-1:0] info;
        logic                 has_child;
        logic                 has_sib;
        logic                 has_info;
    } node_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [NODE_AW-1:0] addr;
        node_t              node;
        logic [SYM_W-1:0]   ch;
    } entry_t;

    // Head of the queue as seen by the back.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

endpackage

// ===== hdl/twl_in_if.sv =====
// ---------------------------------------------------------------------------
// Trie word lookup input channel
// Valid/ready channel that carries node writes and lookup characters.
// ---------------------------------------------------------------------------
interface twl_in_if;

    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] node_addr;
    logic [7:0]  node_symbol;
    logic [15:0] node_child;
    logic [15:0] node_sibling;
    logic [19:0] node_info;
    logic        node_has_child;
    logic        node_has_sibling;
    logic        node_has_info;
    logic [7:0]  lookup_char;
    logic        word_end;

    modport source (
        output valid, kind, node_addr, node_symbol, node_child, node_sibling,
               node_info, node_has_child, node_has_sibling, node_has_info,
               lookup_char, word_end,
        input  ready
    );

    modport sink (
        input  valid, kind, node_addr, node_symbol, node_child, node_sibling,
               node_info, node_has_child, node_has_sibling, node_has_info,
               lookup_char, word_end,
        output ready
    );

endinterface

// ===== hdl/twl_out_if.sv =====
// ---------------------------------------------------------------------------
// Trie word lookup result channel
// Valid/ready channel that carries one lookup result per word.
// ---------------------------------------------------------------------------
interface twl_out_if;

    logic        valid;
    logic        ready;
    logic        found;
    logic [19:0] info_index;

    modport source (
        output valid, found, info_index,
        input  ready
    );

    modport sink (
        input  valid, found, info_index,
        output ready
    );

endinterface

// ===== hdl/twl_front.sv =====
// ---------------------------------------------------------------------------
// Trie word lookup front
// Accepts input beats, classifies them into operations and queues them.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module twl_front (
    input  logic            clk,
    input  logic            rst_n,
    twl_in_if.sink          in_ch,
    output twl_pkg::head_t  head,
    input  logic            pop
);

    twl_pkg::entry_t              q_mem [twl_pkg::QDEPTH];
    logic [twl_pkg::QAW-1:0]      wr_ptr_reg;
    logic [twl_pkg::QAW-1:0]      wr_ptr_next;
    logic [twl_pkg::QAW-1:0]      rd_ptr_reg;
    logic [twl_pkg::QAW-1:0]      rd_ptr_next;
    logic [twl_pkg::QCW-1:0]      cnt_reg;
    logic [twl_pkg::QCW-1:0]      cnt_next;
    logic                         push;
    logic                         do_pop;
    twl_pkg::entry_t              new_entry;

    // Classify the incoming beat.
    always_comb
    begin
        new_entry.addr           = in_ch.node_addr;
        new_entry.node.sym       = in_ch.node_symbol;
        new_entry.node.child     = in_ch.node_child;
        new_entry.node.sib       = in_ch.node_sibling;
        new_entry.node.info      = in_ch.node_info;
        new_entry.node.has_child = in_ch.node_has_child;
        new_entry.node.has_sib   = in_ch.node_has_sibling;
        new_entry.node.has_info  = in_ch.node_has_info;
        new_entry.ch             = in_ch.lookup_char;
        if (!in_ch.kind)
        begin
            new_entry.op = twl_pkg::OP_NODE_WR;
        end
        else if (in_ch.word_end)
        begin
            new_entry.op = twl_pkg::OP_WORD_END;
        end
        else
        begin
            new_entry.op = twl_pkg::OP_CHAR;
        end
    end

    assign in_ch.ready = (cnt_reg != twl_pkg::QCW'(twl_pkg::QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign do_pop      = pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.entry = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `ASSERT_ALWAYS(a_cnt_in_range, clk, rst_n, cnt_reg <= twl_pkg::QCW'(twl_pkg::QDEPTH))
    `ASSERT_IMPLIES(a_pop_not_empty, clk, rst_n, pop, cnt_reg != '0)
    `ASSERT_NEXT(a_push_counts, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

// ===== hdl/twl_back.sv =====
// ---------------------------------------------------------------------------
// Trie word lookup back
// Holds the node table, walks sibling chains and registers word results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module twl_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [twl_pkg::NODE_AW-1:0]   root_node,
    input  twl_pkg::head_t                head,
    output logic                          pop,
    twl_out_if.source                     out_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROOT = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    twl_pkg::node_t                   node_mem [twl_pkg::NODE_COUNT];
    twl_pkg::node_t                   node_rd_reg;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [twl_pkg::NODE_AW-1:0]      cur_reg;
    logic [twl_pkg::NODE_AW-1:0]      cur_next;
    logic [twl_pkg::NODE_AW-1:0]      step_reg;
    logic [twl_pkg::NODE_AW-1:0]      step_next;
    logic                             in_word_reg;
    logic                             in_word_next;
    logic                             failed_reg;
    logic                             failed_next;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             found_reg;
    logic [twl_pkg::INFO_BITS-1:0]    info_reg;

    logic                             mem_we;
    logic                             mem_re;
    logic [twl_pkg::NODE_AW-1:0]      rd_addr;
    logic                             out_free;
    logic                             out_load;
    logic                             res_found;
    logic [twl_pkg::INFO_BITS-1:0]    res_info;
    logic                             is_last;
    logic                             hit;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign is_last  = (head.entry.op == twl_pkg::OP_WORD_END);
    assign hit      = (node_rd_reg.sym == head.entry.ch);

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        step_next    = step_reg;
        in_word_next = in_word_reg;
        failed_next  = failed_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        rd_addr      = cur_reg;
        pop          = 1'b0;
        out_load     = 1'b0;
        res_found    = 1'b0;
        res_info     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    unique case (head.entry.op)
                        twl_pkg::OP_NODE_WR:
                        begin
                            mem_we = 1'b1;
                            pop    = 1'b1;
                        end
                        twl_pkg::OP_CHAR, twl_pkg::OP_WORD_END:
                        begin
                            if (in_word_reg && failed_reg)
                            begin
                                // The word already failed: skip the character.
                                if (!is_last)
                                begin
                                    pop = 1'b1;
                                end
                                else if (out_free)
                                begin
                                    pop          = 1'b1;
                                    out_load     = 1'b1;
                                    in_word_next = 1'b0;
                                    failed_next  = 1'b0;
                                end
                            end
                            else if (!in_word_reg)
                            begin
                                mem_re     = 1'b1;
                                rd_addr    = root_node;
                                state_next = ST_ROOT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                rd_addr    = cur_reg;
                                step_next  = '0;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_ROOT:
            begin
                in_word_next = 1'b1;
                failed_next  = 1'b0;
                cur_next     = node_rd_reg.child;
                mem_re       = 1'b1;
                rd_addr      = node_rd_reg.child;
                step_next    = '0;
                state_next   = ST_WALK;
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    if (!is_last)
                    begin
                        pop        = 1'b1;
                        state_next = ST_IDLE;
                        if (node_rd_reg.has_child)
                        begin
                            cur_next = node_rd_reg.child;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else if (out_free)
                    begin
                        pop          = 1'b1;
                        out_load     = 1'b1;
                        res_found    = node_rd_reg.has_info;
                        res_info     = node_rd_reg.has_info ? node_rd_reg.info : '0;
                        in_word_next = 1'b0;
                        failed_next  = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
                else if (!node_rd_reg.has_sib || (step_reg == '1))
                begin
                    // End of the chain, or a full table's worth of steps.
                    if (!is_last)
                    begin
                        pop         = 1'b1;
                        failed_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        pop          = 1'b1;
                        out_load     = 1'b1;
                        in_word_next = 1'b0;
                        failed_next  = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    mem_re    = 1'b1;
                    rd_addr   = node_rd_reg.sib;
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Node table: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[head.entry.addr] <= head.entry.node;
        end
        if (mem_re)
        begin
            node_rd_reg <= node_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            found_reg <= res_found;
            info_reg  <= res_info;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            step_reg      <= '0;
            in_word_reg   <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            step_reg      <= step_next;
            in_word_reg   <= in_word_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.found      = found_reg;
    assign out_ch.info_index = info_reg;

    `ASSERT_IMPLIES(a_load_when_free, clk, rst_n, out_load, out_free)
    `ASSERT_IMPLIES(a_write_in_idle, clk, rst_n, mem_we, state_reg == ST_IDLE)
    `ASSERT_NEXT(a_root_enters_walk, clk, rst_n, state_reg == ST_ROOT,
                 state_reg == ST_WALK && in_word_reg && !failed_reg)

endmodule

// ===== hdl/trie_word_lookup_unit.sv =====
// ---------------------------------------------------------------------------
// Trie word lookup unit
// Looks words up in a first-child / next-sibling trie held in a node table.
// ---------------------------------------------------------------------------
//
//  Channel    Direction  Beat carries
//  in_ch      in         one node write, or one character of a word
//  out_ch     out        found flag and info index, one per word
//  cfg_we     in         write strobe for the root node index (cfg_wdata)
//
// A node write is done in the back's idle state. A lookup character is read
// in the idle state and compared in the walk state, with one more read per
// sibling visited before the match; the first character of a word also
// passes the root state for the read of the root node; the node table's
// single read port sets this order. There is no clearing pass after reset:
// the node table is undefined until written, and only control state is reset.
// A result waits in the output register while the back keeps working on
// characters that do not end a word; input beats stall only when the
// four-entry queue is full.
//
// The front takes every input beat as soon as there is room in the queue and
// tags it as a node write, an inner character or a word-ending character.
// The back drains the queue in order, so node writes and lookups see each
// other exactly in arrival order. After a character fails to match, the
// remaining characters of that word are dropped and the word still returns
// one not-found result on its last character. A sibling chain that loops is
// cut after one full table's worth of steps.
// ---------------------------------------------------------------------------
module trie_word_lookup_unit (
    input  logic         clk,
    input  logic         rst_n,
    twl_in_if.sink       in_ch,
    twl_out_if.source    out_ch,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);

    // Root node index; the search for a word starts at the root's child link.
    logic [twl_pkg::NODE_AW-1:0] root_reg;
    logic [twl_pkg::NODE_AW-1:0] root_next;

    twl_pkg::head_t head;
    logic           pop;

    assign root_next = cfg_we ? cfg_wdata : root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else
        begin
            root_reg <= root_next;
        end
    end

    // Front: accept and classify beats into the queue.
    twl_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .head  (head),
        .pop   (pop)
    );

    // Back: node table, sibling walk and the result register.
    twl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .root_node (root_reg),
        .head      (head),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule
